FILE: design/pqs_pkg.sv
package pqs_pkg;

	// coordinate width and derived widths
	localparam int CoordBits = 12;
	localparam int SizeW     = CoordBits + 1;
	localparam int LvlW      = $clog2(CoordBits + 1);
	localparam int CandW     = 2 * CoordBits + 1;
	localparam int CountW    = 2 * CoordBits + 1;
	localparam int ProdW     = 2 * SizeW;

	// configuration register indexes
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 1'b1;

	// frame geometry resolved once per transaction
	typedef struct packed {
		logic [SizeW-1:0]  width;
		logic [SizeW-1:0]  height;
		logic [LvlW-1:0]   levels;
		logic [CandW-1:0]  limit;
		logic [CountW-1:0] total;
	} pqs_geom_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SETUP  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_DONE   = 4'b1000
	} pqs_state_t;

endpackage

FILE: design/pqs_req_if.sv
interface pqs_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

FILE: design/pqs_res_if.sv
interface pqs_res_if import pqs_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CoordBits-1:0] coord_x;
	logic [CoordBits-1:0] coord_y;
	logic                 last;

	modport source (output valid, output coord_x, output coord_y, output last, input ready);
	modport sink (input valid, input coord_x, input coord_y, input last, output ready);
endinterface

FILE: design/pqs_geom.sv
module pqs_geom import pqs_pkg::*; (
	input  logic [SizeW-1:0] frame_width,
	input  logic [SizeW-1:0] frame_height,
	output pqs_geom_t        geom
);

	localparam logic [SizeW-1:0] SizeTop = SizeW'(1) << CoordBits;

	logic [SizeW-1:0] w;
	logic [SizeW-1:0] h;
	logic [SizeW-1:0] m_minus1;
	logic [LvlW-1:0]  lv;
	logic [ProdW-1:0] prod;

	// clamp to 1..2^CoordBits
	always_comb begin
		if (frame_width == '0) begin
			w = SizeW'(1);
		end else if (frame_width > SizeTop) begin
			w = SizeTop;
		end else begin
			w = frame_width;
		end
		if (frame_height == '0) begin
			h = SizeW'(1);
		end else if (frame_height > SizeTop) begin
			h = SizeTop;
		end else begin
			h = frame_height;
		end
	end

	// levels = bit length of max(w,h)-1
	always_comb begin
		m_minus1 = ((w > h) ? w : h) - SizeW'(1);
		lv = '0;
		for (int i = 0; i < CoordBits; i++) begin
			if (m_minus1[i]) begin
				lv = LvlW'(i + 1);
			end
		end
	end

	assign prod = w * h;

	assign geom.width  = w;
	assign geom.height = h;
	assign geom.levels = lv;
	assign geom.limit  = CandW'(1) << {lv, 1'b0};
	assign geom.total  = prod[CountW-1:0];

endmodule

FILE: design/pqs_cand_unit.sv
module pqs_cand_unit import pqs_pkg::*; (
	input  logic [CandW-1:0]     cand,
	input  pqs_geom_t            geom,
	output logic [CoordBits-1:0] x,
	output logic [CoordBits-1:0] y,
	output logic                 hit
);

	logic [2*CoordBits-1:0] aligned;
	logic [LvlW:0]          shamt;
	logic [1:0]             dig;

	// left-align the used digits so digit i sits at a fixed place
	assign shamt   = {LvlW'(CoordBits) - geom.levels, 1'b0};
	assign aligned = cand[2*CoordBits-1:0] << shamt;

	always_comb begin
		x   = '0;
		y   = '0;
		dig = '0;
		for (int i = 0; i < CoordBits; i++) begin
			dig  = aligned[2*(CoordBits-1-i) +: 2];
			x[i] = dig[0] ^ dig[1];
			y[i] = dig[0];
		end
	end

	assign hit = ({1'b0, x} < geom.width) && ({1'b0, y} < geom.height);

endmodule

FILE: design/progressive_quad_scan_address_gen.sv
// channel  dir  fields                      role
// cfg      in   cfg_wen cfg_index cfg_data  frame_width (0), frame_height (1) writes
// req      in   restart                     one transaction asks for the next coordinate
// res      out  coord_x coord_y last        one coordinate per request transaction
//
// per request the shared decode/compare unit tests candidates (one per cycle)
//   until one hits; near-square frames need fewer candidates than thin ones
// one request at a time: req.ready is high only while the sequencer is idle
// res is a registered output; a stalled result holds the sequencer in its last
//   step until the slot frees
// reset clears the scan position and sets both frame sizes to 1
module progressive_quad_scan_address_gen import pqs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [SizeW-1:0]   cfg_data,
	pqs_req_if.sink            req,
	pqs_res_if.source          res
);

	pqs_state_t state_q;

	// configuration
	logic [SizeW-1:0] width_q;
	logic [SizeW-1:0] height_q;

	// scan position
	logic [CandW-1:0]  cand_q;
	logic [CountW-1:0] count_q;

	// geometry latched at the start of each request
	pqs_geom_t geom_c;
	pqs_geom_t geom_q;

	// shared candidate unit
	logic                 wrap;
	logic [CandW-1:0]     cand_eff;
	logic [CoordBits-1:0] cand_x;
	logic [CoordBits-1:0] cand_y;
	logic                 cand_hit;

	// found coordinate waiting to go out
	logic [CoordBits-1:0] hit_x_q;
	logic [CoordBits-1:0] hit_y_q;
	logic [CountW-1:0]    count_next;
	logic                 is_last;
	logic                 res_load;

	// output register
	logic                 res_valid_q;
	logic [CoordBits-1:0] res_x_q;
	logic [CoordBits-1:0] res_y_q;
	logic                 res_last_q;

	pqs_geom u_geom (
		.frame_width  (width_q),
		.frame_height (height_q),
		.geom         (geom_c)
	);

	// candidates past the last level wrap to a fresh pass
	assign wrap     = (cand_q >= geom_q.limit);
	assign cand_eff = wrap ? '0 : cand_q;

	pqs_cand_unit u_cand (
		.cand (cand_eff),
		.geom (geom_q),
		.x    (cand_x),
		.y    (cand_y),
		.hit  (cand_hit)
	);

	assign count_next = count_q + CountW'(1);
	assign is_last    = (count_next >= geom_q.total);
	assign res_load   = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	assign req.ready   = (state_q == ST_IDLE);
	assign res.valid   = res_valid_q;
	assign res.coord_x = res_x_q;
	assign res.coord_y = res_y_q;
	assign res.last    = res_last_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SizeW'(1);
			height_q <= SizeW'(1);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cand_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (req.restart) begin
							cand_q  <= '0;
							count_q <= '0;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					// one candidate per cycle
					cand_q <= cand_eff + CandW'(1);
					if (wrap) begin
						count_q <= '0;
					end
					if (cand_hit) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						if (is_last) begin
							cand_q  <= '0;
							count_q <= '0;
						end else begin
							count_q <= count_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			geom_q <= geom_c;
		end
		if (state_q == ST_SEARCH && cand_hit) begin
			hit_x_q <= cand_x;
			hit_y_q <= cand_y;
		end
		if (res_load) begin
			res_x_q    <= hit_x_q;
			res_y_q    <= hit_y_q;
			res_last_q <= is_last;
		end
	end

endmodule
